// File: rtl/minimum_image_distance_squared_macros.svh
// Assertion macros shared by the minimum-image distance RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef MINIMUM_IMAGE_DISTANCE_SQUARED_MACROS_SVH
`define MINIMUM_IMAGE_DISTANCE_SQUARED_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MIDS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mids_pkg.sv
// Package for the minimum-image distance block: widths, pipeline depths and
// register indexes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mids_pkg;

	localparam int COORD_W   = 32;
	localparam int BOX_W     = 31;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 61;
	localparam int DIST_W    = 62;
	localparam int CFG_IDX_W = 2;

	// Remainder unit: restoring, DIV_STEPS bits per stage.
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (DIFF_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DVD_W      = DIV_STAGES * DIV_STEPS;

	// Fold unit registers: difference, remainder stages, final fold.
	localparam int FOLD_LAT = DIV_STAGES + 2;
	// Plus the square stage and the sum stage.
	localparam int LATENCY  = FOLD_LAT + 2;

	localparam logic [BOX_W-1:0]  BOX_RESET = BOX_W'(655360);
	localparam logic [DIST_W-1:0] DIST_MAX  = DIST_W'(64'h3000_0000_0000_0000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_X = 2'd0,
		REG_BOX_Y = 2'd1,
		REG_BOX_Z = 2'd2
	} cfg_reg_t;

	// Pipeline control handed to each fold unit.
	typedef struct packed {
		logic en;
	} fold_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/mids_if.sv
// Valid/ready channel interfaces for the atom pair and the distance result.
// Depends on mids_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mids_pair_if;
	logic valid;
	logic ready;
	logic signed [mids_pkg::COORD_W-1:0] first_x;
	logic signed [mids_pkg::COORD_W-1:0] first_y;
	logic signed [mids_pkg::COORD_W-1:0] first_z;
	logic signed [mids_pkg::COORD_W-1:0] second_x;
	logic signed [mids_pkg::COORD_W-1:0] second_y;
	logic signed [mids_pkg::COORD_W-1:0] second_z;

	modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
		input ready);
	modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
		output ready);
endinterface

interface mids_result_if;
	logic valid;
	logic ready;
	logic signed [mids_pkg::COORD_W-1:0] dr_x;
	logic signed [mids_pkg::COORD_W-1:0] dr_y;
	logic signed [mids_pkg::COORD_W-1:0] dr_z;
	logic [mids_pkg::DIST_W-1:0]         dist_sq;

	modport source (output valid, dr_x, dr_y, dr_z, dist_sq, input ready);
	modport sink (input valid, dr_x, dr_y, dr_z, dist_sq, output ready);
endinterface

`default_nettype wire

// File: rtl/minimum_image_distance_squared.sv
// Minimum-image separation and squared distance of two atoms in a periodic box.
//
// Channels: pair (sink) carries the two signed Q15.16 positions; result (source)
// carries dr_x, dr_y, dr_z (Q15.16) and dist_sq (unsigned, 32 fraction bits).
// A transaction completes on a rising edge with valid and ready both high.
// Box lengths are written through cfg_we / cfg_index / cfg_data: index 0 is x,
// 1 is y, 2 is z, index 3 is ignored. Write them only while the block is empty.
// A box of zero behaves as one unit in the last place.
//
// From pair transaction to result valid the pipeline has one difference
// stage, nine remainder stages of four restoring steps each, one fold stage,
// one square stage and one sum stage. A new pair is taken every cycle
// unless the result receiver stalls: then the whole pipeline holds and
// pair.ready falls in the same cycle; nothing is lost or repeated.
// Reset clears the valid bits and restores every box length to 10.0.
`timescale 1ns / 1ps
`default_nettype none

module minimum_image_distance_squared (
	input  logic                              clk,
	input  logic                              arst_n,
	mids_pair_if.sink                         pair,
	mids_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [mids_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mids_pkg::BOX_W-1:0]        cfg_data
);
	import mids_pkg::*;

	`include "minimum_image_distance_squared_macros.svh"

	logic [BOX_W-1:0]          box_x_q, box_y_q, box_z_q;
	logic [BOX_W-1:0]          len_x, len_y, len_z;
	logic                      en;
	fold_ctrl_t                ctrl;
	logic [LATENCY-1:0]        vld_s;
	logic signed [COORD_W-1:0] dr_x, dr_y, dr_z;
	logic [BOX_W-1:0]          mag_x, mag_y, mag_z;
	logic signed [COORD_W-1:0] dr_x_s12, dr_y_s12, dr_z_s12;
	logic signed [COORD_W-1:0] dr_x_s13, dr_y_s13, dr_z_s13;
	logic [SQ_W-1:0]           sqx_s12, sqy_s12, sqz_s12;
	logic [DIST_W-1:0]         dist_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_q <= BOX_RESET;
			box_y_q <= BOX_RESET;
			box_z_q <= BOX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_X: box_x_q <= cfg_data;
				REG_BOX_Y: box_y_q <= cfg_data;
				REG_BOX_Z: box_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign len_x = (box_x_q == '0) ? BOX_W'(1) : box_x_q;
	assign len_y = (box_y_q == '0) ? BOX_W'(1) : box_y_q;
	assign len_z = (box_z_q == '0) ? BOX_W'(1) : box_z_q;

	// The pipeline moves as one unless a finished result is waiting.
	assign en         = !vld_s[LATENCY-1] || result.ready;
	assign ctrl.en    = en;
	assign pair.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LATENCY-2:0], pair.valid};
		end
	end

	mids_fold u_fold_x (
		.clk(clk), .ctrl(ctrl), .a(pair.first_x), .b(pair.second_x), .len(len_x),
		.dr(dr_x), .mag(mag_x)
	);
	mids_fold u_fold_y (
		.clk(clk), .ctrl(ctrl), .a(pair.first_y), .b(pair.second_y), .len(len_y),
		.dr(dr_y), .mag(mag_y)
	);
	mids_fold u_fold_z (
		.clk(clk), .ctrl(ctrl), .a(pair.first_z), .b(pair.second_z), .len(len_z),
		.dr(dr_z), .mag(mag_z)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s12  <= SQ_W'({{BOX_W{1'b0}}, mag_x} * {{BOX_W{1'b0}}, mag_x});
			sqy_s12  <= SQ_W'({{BOX_W{1'b0}}, mag_y} * {{BOX_W{1'b0}}, mag_y});
			sqz_s12  <= SQ_W'({{BOX_W{1'b0}}, mag_z} * {{BOX_W{1'b0}}, mag_z});
			dr_x_s12 <= dr_x;
			dr_y_s12 <= dr_y;
			dr_z_s12 <= dr_z;
			dist_s13 <= DIST_W'(sqx_s12) + DIST_W'(sqy_s12) + DIST_W'(sqz_s12);
			dr_x_s13 <= dr_x_s12;
			dr_y_s13 <= dr_y_s12;
			dr_z_s13 <= dr_z_s12;
		end
	end

	assign result.valid   = vld_s[LATENCY-1];
	assign result.dr_x    = dr_x_s13;
	assign result.dr_y    = dr_y_s13;
	assign result.dr_z    = dr_z_s13;
	assign result.dist_sq = dist_s13;

	`MIDS_ASSERT_IMPL(a_fold_x_half, vld_s[FOLD_LAT-1],
		{mag_x, 1'b0} <= {1'b0, len_x}, "x component outside half box")
	`MIDS_ASSERT_IMPL(a_fold_z_sign, vld_s[FOLD_LAT-1],
		(dr_z == COORD_W'(mag_z)) || (dr_z == -COORD_W'(mag_z)),
		"z component and magnitude disagree")
	`MIDS_ASSERT_IMPL(a_dist_bound, result.valid,
		result.dist_sq <= DIST_MAX, "squared distance above bound")
	`MIDS_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_s), "pipeline moved during a stall")

endmodule

`default_nettype wire

// File: rtl/mids_fold.sv
// One axis of the minimum-image fold: difference, pipelined restoring remainder
// by the box length, and the final shift into the half-open half-box range. Uses mids_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mids_fold (
	input  logic                                clk,
	input  mids_pkg::fold_ctrl_t                ctrl,
	input  logic signed [mids_pkg::COORD_W-1:0] a,
	input  logic signed [mids_pkg::COORD_W-1:0] b,
	input  logic [mids_pkg::BOX_W-1:0]          len,
	output logic signed [mids_pkg::COORD_W-1:0] dr,
	output logic [mids_pkg::BOX_W-1:0]          mag
);
	import mids_pkg::*;

	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_mag;
	logic [DVD_W-1:0]         dvd_s [0:DIV_STAGES];
	logic [BOX_W-1:0]         rem_s [0:DIV_STAGES];
	logic                     neg_s [0:DIV_STAGES];
	logic [BOX_W-1:0]         m;
	logic                     over;

	assign diff     = {b[COORD_W-1], b} - {a[COORD_W-1], a};
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			dvd_s[0] <= DVD_W'(diff_mag);
			rem_s[0] <= '0;
			neg_s[0] <= diff[DIFF_W-1];
		end
	end

	// Each stage brings down DIV_STEPS dividend bits, most significant first.
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic [BOX_W:0]   sh;
		logic [BOX_W-1:0] r;

		always_comb begin
			r  = rem_s[k];
			sh = '0;
			for (int j = 0; j < DIV_STEPS; j++) begin
				sh = {r, dvd_s[k][DVD_W-1-j]};
				if (sh >= {1'b0, len}) begin
					r = BOX_W'(sh - {1'b0, len});
				end else begin
					r = sh[BOX_W-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			if (ctrl.en) begin
				dvd_s[k+1] <= dvd_s[k] << DIV_STEPS;
				rem_s[k+1] <= r;
				neg_s[k+1] <= neg_s[k];
			end
		end
	end

	// A negative difference with a non-zero remainder lands at len minus the remainder.
	assign m = (neg_s[DIV_STAGES] && (rem_s[DIV_STAGES] != '0)) ?
		BOX_W'(len - rem_s[DIV_STAGES]) : rem_s[DIV_STAGES];
	assign over = {m, 1'b0} > {1'b0, len};

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			dr  <= over ? COORD_W'({1'b0, m} - {1'b0, len}) : COORD_W'({1'b0, m});
			mag <= over ? BOX_W'(len - m) : m;
		end
	end

endmodule

`default_nettype wire
